// ===== rtl/core/lds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lds_pkg;

   localparam int CAPACITY_DEFAULT   = 32;
   localparam int TRACK_BITS_DEFAULT = 10;
   localparam int TAG_BITS_DEFAULT   = 16;

   typedef enum logic [0:0] {
      OP_ADD = 1'b0,
      OP_GET = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Control from the sequencer to the picker.
   typedef struct packed {
      logic clear;
      logic sample;
   } pick_ctrl_type;

   // Outcome of a finished scan.
   typedef struct packed {
      logic found;
      logic flip;
   } pick_flags_type;

endpackage

`default_nettype wire

// ===== rtl/core/lds_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lds_pick.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lds_pick
   import lds_pkg::*;
#(
   parameter int TRACK_BITS = TRACK_BITS_DEFAULT,
   parameter int TAG_BITS   = TAG_BITS_DEFAULT,
   parameter int RANK_BITS  = 6,
   parameter int IDX_BITS   = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pick_ctrl_type         ctrl,
   input  wire logic                  dir_inward,
   input  wire logic [TRACK_BITS-1:0] cur_track,
   input  wire logic [IDX_BITS-1:0]   ent_idx,
   input  wire logic [TRACK_BITS-1:0] ent_track,
   input  wire logic [TAG_BITS-1:0]   ent_tag,
   input  wire logic [RANK_BITS-1:0]  ent_rank,
   output pick_flags_type             flags,
   output logic      [IDX_BITS-1:0]   sel_idx,
   output logic      [TRACK_BITS-1:0] sel_track,
   output logic      [TAG_BITS-1:0]   sel_tag,
   output logic      [RANK_BITS-1:0]  sel_rank
);

   // Best candidate at or below the current track (inward) and at or above it
   // (outward). Among equal tracks the higher rank, the newer request, wins.
   logic                  in_found_ff,  out_found_ff;
   logic [IDX_BITS-1:0]   in_idx_ff,    out_idx_ff;
   logic [TRACK_BITS-1:0] in_track_ff,  out_track_ff;
   logic [TAG_BITS-1:0]   in_tag_ff,    out_tag_ff;
   logic [RANK_BITS-1:0]  in_rank_ff,   out_rank_ff;
   logic                  in_take, out_take, use_in;

   always_comb begin
      in_take = ctrl.sample && (ent_track <= cur_track) &&
                (!in_found_ff || (ent_track > in_track_ff) ||
                 ((ent_track == in_track_ff) && (ent_rank > in_rank_ff)));
      out_take = ctrl.sample && (ent_track >= cur_track) &&
                 (!out_found_ff || (ent_track < out_track_ff) ||
                  ((ent_track == out_track_ff) && (ent_rank > out_rank_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         in_found_ff  <= 1'b0;
         out_found_ff <= 1'b0;
      end else begin
         if (in_take) begin
            in_found_ff <= 1'b1;
         end
         if (out_take) begin
            out_found_ff <= 1'b1;
         end
      end
      if (in_take) begin
         in_idx_ff   <= ent_idx;
         in_track_ff <= ent_track;
         in_tag_ff   <= ent_tag;
         in_rank_ff  <= ent_rank;
      end
      if (out_take) begin
         out_idx_ff   <= ent_idx;
         out_track_ff <= ent_track;
         out_tag_ff   <= ent_tag;
         out_rank_ff  <= ent_rank;
      end
   end

   always_comb begin
      use_in      = dir_inward ? in_found_ff : !out_found_ff;
      flags.found = in_found_ff || out_found_ff;
      flags.flip  = dir_inward ? !in_found_ff : !out_found_ff;
      sel_idx     = use_in ? in_idx_ff   : out_idx_ff;
      sel_track   = use_in ? in_track_ff : out_track_ff;
      sel_tag     = use_in ? in_tag_ff   : out_tag_ff;
      sel_rank    = use_in ? in_rank_ff  : out_rank_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/core/look_disk_request_scheduler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  opcode, track, tag, head track
// rsp       out        rsp_valid/rsp_stall  status, served tag/track, sweep, count
//
// An add goes through accept, one memory write and result load.
// A get is one pass of the single read port of the entry memory over all pending
// entries, then a tail step, decide and result load.
// Errors (get on empty, add to full) go from accept straight to result load.
// Reset is synchronous and needs no clearing pass; only slots below the count
// are ever read. A stalled result holds in the output register while the next
// word is accepted and worked on; only its own result load waits.

module look_disk_request_scheduler_unit
   import lds_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEFAULT,
   parameter int TRACK_BITS = TRACK_BITS_DEFAULT,
   parameter int TAG_BITS   = TAG_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_opcode,
   input  wire logic [TRACK_BITS-1:0]          req_track,
   input  wire logic [TAG_BITS-1:0]            req_tag,
   input  wire logic [TRACK_BITS-1:0]          req_head_track,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [1:0]                     rsp_status,
   output logic      [TAG_BITS-1:0]            rsp_served_tag,
   output logic      [TRACK_BITS-1:0]          rsp_served_track,
   output logic                                rsp_sweep_inward,
   output logic      [$clog2(CAPACITY+1)-1:0]  rsp_pending_count
);

   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int RANK_BITS  = CNT_BITS;
   localparam int ENTRY_BITS = TRACK_BITS + TAG_BITS + RANK_BITS;

   // Entries are held unsorted in slots 0 .. count-1. Each carries a rank that
   // orders requests by age (higher is newer), which settles ties between equal
   // tracks. Removing a request leaves a gap in the ranks; rather than renumber
   // at once, the removed rank is kept as a pending correction and applied to
   // every entry, and written back, during the next get's scan. The hole left
   // by a served request is filled with the last slot's entry.

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_TAIL,
      ST_DECIDE,
      ST_RESP
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  dir_ff, dir_in;
   logic [TRACK_BITS-1:0] cur_track_ff, cur_track_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [RANK_BITS-1:0]  pend_rank_ff, pend_rank_in;
   logic [TRACK_BITS-1:0] trk_ff, trk_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [TRACK_BITS-1:0] head_ff, head_in;
   logic [IDX_BITS-1:0]   rd_idx_ff, rd_idx_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [IDX_BITS-1:0]   rd_slot_ff, rd_slot_in;
   logic [ENTRY_BITS-1:0] last_ff, last_in;
   status_type            res_status_ff, res_status_in;
   logic [TAG_BITS-1:0]   res_tag_ff, res_tag_in;
   logic [TRACK_BITS-1:0] res_track_ff, res_track_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [TAG_BITS-1:0]   rsp_tag_ff, rsp_tag_in;
   logic [TRACK_BITS-1:0] rsp_track_ff, rsp_track_in;
   logic                  rsp_dir_ff, rsp_dir_in;
   logic [CNT_BITS-1:0]   rsp_count_ff, rsp_count_in;

   logic                  wr_en, rd_en;
   logic [IDX_BITS-1:0]   wr_addr, rd_addr;
   logic [ENTRY_BITS-1:0] wr_data, rd_data;
   logic [CNT_BITS-1:0]   cnt_dec;
   logic [IDX_BITS-1:0]   last_idx;
   logic [TRACK_BITS-1:0] ent_track;
   logic [TAG_BITS-1:0]   ent_tag;
   logic [RANK_BITS-1:0]  ent_rank_raw, ent_rank;
   logic [ENTRY_BITS-1:0] ent_fixed;
   logic                  full, empty;

   pick_ctrl_type         pick_ctrl;
   pick_flags_type        pick_flags;
   logic [IDX_BITS-1:0]   sel_idx;
   logic [TRACK_BITS-1:0] sel_track;
   logic [TAG_BITS-1:0]   sel_tag;
   logic [RANK_BITS-1:0]  sel_rank;

   lds_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lds_pick #(
      .TRACK_BITS (TRACK_BITS),
      .TAG_BITS   (TAG_BITS),
      .RANK_BITS  (RANK_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_pick (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (pick_ctrl),
      .dir_inward (dir_ff),
      .cur_track  (cur_track_ff),
      .ent_idx    (rd_slot_ff),
      .ent_track  (ent_track),
      .ent_tag    (ent_tag),
      .ent_rank   (ent_rank),
      .flags      (pick_flags),
      .sel_idx    (sel_idx),
      .sel_track  (sel_track),
      .sel_tag    (sel_tag),
      .sel_rank   (sel_rank)
   );

   // Entry word coming back from memory, with the pending rank correction.
   always_comb begin
      ent_track    = rd_data[ENTRY_BITS-1 -: TRACK_BITS];
      ent_tag      = rd_data[RANK_BITS +: TAG_BITS];
      ent_rank_raw = rd_data[RANK_BITS-1:0];
      ent_rank     = (pend_valid_ff && (ent_rank_raw > pend_rank_ff)) ?
                     ent_rank_raw - 1'b1 : ent_rank_raw;
      ent_fixed    = {ent_track, ent_tag, ent_rank};
      cnt_dec      = count_ff - 1'b1;
      last_idx     = cnt_dec[IDX_BITS-1:0];
      full         = (count_ff == CNT_BITS'(CAPACITY));
      empty        = (count_ff == '0);
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dir_in        = dir_ff;
      cur_track_in  = cur_track_ff;
      pend_valid_in = pend_valid_ff;
      pend_rank_in  = pend_rank_ff;
      trk_in        = trk_ff;
      tag_in        = tag_ff;
      head_in       = head_ff;
      rd_idx_in     = rd_idx_ff;
      rd_valid_in   = 1'b0;
      rd_slot_in    = rd_idx_ff;
      last_in       = last_ff;
      res_status_in = res_status_ff;
      res_tag_in    = res_tag_ff;
      res_track_in  = res_track_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_track_in  = rsp_track_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = rd_slot_ff;
      wr_data       = ent_fixed;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff;
      pick_ctrl     = '{clear: 1'b0, sample: rd_valid_ff};

      // Scan write-back: each entry returns to its slot with its rank fixed.
      if (rd_valid_ff) begin
         wr_en = 1'b1;
         if (rd_slot_ff == last_idx) begin
            last_in = ent_fixed;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               trk_in       = req_track;
               tag_in       = req_tag;
               head_in      = req_head_track;
               res_tag_in   = '0;
               res_track_in = '0;
               if (req_opcode == OP_ADD) begin
                  if (full) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_RESP;
                  end else begin
                     state_in = ST_ADD;
                  end
               end else begin
                  if (empty) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_RESP;
                  end else begin
                     rd_idx_in       = '0;
                     pick_ctrl.clear = 1'b1;
                     state_in        = ST_SCAN;
                  end
               end
            end
         end
         ST_ADD: begin
            // New requests append at slot count with the highest rank.
            wr_en    = 1'b1;
            wr_addr  = count_ff[IDX_BITS-1:0];
            wr_data  = {trk_ff, tag_ff, count_ff + {{(CNT_BITS-1){1'b0}}, pend_valid_ff}};
            count_in = count_ff + 1'b1;
            if (empty) begin
               dir_in = (head_ff > trk_ff);
            end
            res_status_in = STATUS_OK;
            state_in      = ST_RESP;
         end
         ST_SCAN: begin
            rd_en       = 1'b1;
            rd_valid_in = 1'b1;
            if (rd_idx_ff == last_idx) begin
               state_in = ST_TAIL;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         ST_TAIL: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (pick_flags.flip) begin
               dir_in = !dir_ff;
            end
            cur_track_in  = sel_track;
            res_status_in = STATUS_OK;
            res_tag_in    = sel_tag;
            res_track_in  = sel_track;
            pend_valid_in = 1'b1;
            pend_rank_in  = sel_rank;
            count_in      = cnt_dec;
            // Fill the hole with the last entry unless the hole is the last slot.
            if (sel_idx != last_idx) begin
               wr_en   = 1'b1;
               wr_addr = sel_idx;
               wr_data = last_ff;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_tag_in    = res_tag_ff;
               rsp_track_in  = res_track_ff;
               rsp_dir_in    = dir_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         dir_ff        <= 1'b0;
         cur_track_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dir_ff        <= dir_in;
         cur_track_ff  <= cur_track_in;
         pend_valid_ff <= pend_valid_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_rank_ff  <= pend_rank_in;
      trk_ff        <= trk_in;
      tag_ff        <= tag_in;
      head_ff       <= head_in;
      rd_idx_ff     <= rd_idx_in;
      rd_slot_ff    <= rd_slot_in;
      last_ff       <= last_in;
      res_status_ff <= res_status_in;
      res_tag_ff    <= res_tag_in;
      res_track_ff  <= res_track_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_track_ff  <= rsp_track_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_served_tag    = rsp_tag_ff;
   assign rsp_served_track  = rsp_track_ff;
   assign rsp_sweep_inward  = rsp_dir_ff;
   assign rsp_pending_count = rsp_count_ff;

   // A scan over a nonempty queue always finds a request in one direction.
   a_pick_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> pick_flags.found)
      else $error("scan finished without a candidate");

   // The held count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(CAPACITY))
      else $error("pending count beyond capacity");

   // An accepted word always leaves the idle state for its work.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted word not taken up");

   // A full-queue error is only reported while the queue is full.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |->
      (rsp_pending_count == CNT_BITS'(CAPACITY)))
      else $error("full status with room left");

endmodule

`default_nettype wire

// ===== tb/lds_service_checker.sv =====
`timescale 1ns / 1ps

module lds_service_checker
   import lds_pkg::*;
#(
   parameter int CAP      = CAPACITY_DEFAULT,
   parameter int TRK_W    = TRACK_BITS_DEFAULT,
   parameter int TAG_W    = TAG_BITS_DEFAULT,
   parameter int CNT_W    = $clog2(CAPACITY_DEFAULT + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_opcode,
   input  logic [TRK_W-1:0]  req_track,
   input  logic [TAG_W-1:0]  req_tag,
   input  logic [TRK_W-1:0]  req_head_track,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [1:0]        rsp_status,
   input  logic [TAG_W-1:0]  rsp_served_tag,
   input  logic [TRK_W-1:0]  rsp_served_track,
   input  logic              rsp_sweep_inward,
   input  logic [CNT_W-1:0]  rsp_pending_count,
   output int unsigned       mismatch_count,
   output int unsigned       results_owed
);

   typedef struct packed {
      status_type        status;
      logic [TAG_W-1:0]  tag;
      logic [TRK_W-1:0]  track;
      logic              inward;
      logic [CNT_W-1:0]  count;
   } sched_result_type;

   // Shadow of the pending requests, sorted by ascending track.
   logic [TRK_W-1:0] pend_track [CAP];
   logic [TAG_W-1:0] pend_tag   [CAP];
   int               pend_count;
   logic             sweep_in;
   logic [TRK_W-1:0] head_pos;

   sched_result_type expected_q [$];

   // Index of the request to serve in the given direction, or -1 if none lies that way.
   // Among equal tracks the one nearest the front of the list wins.
   function automatic int find_served(logic inward);
      int hit;
      hit = -1;
      if (inward) begin
         for (int i = 0; i < pend_count; i++)
            if (pend_track[i] <= head_pos) hit = i;
         while (hit > 0 && pend_track[hit-1] == pend_track[hit]) hit--;
      end else begin
         for (int i = pend_count - 1; i >= 0; i--)
            if (pend_track[i] >= head_pos) hit = i;
      end
      return hit;
   endfunction

   function automatic sched_result_type apply_word(logic op, logic [TRK_W-1:0] trk,
                                                   logic [TAG_W-1:0] tag,
                                                   logic [TRK_W-1:0] head);
      sched_result_type res;
      int               pos;
      int               k;
      res = '0;
      res.status = STATUS_OK;
      if (op == OP_ADD) begin
         if (pend_count >= CAP) begin
            res.status = STATUS_FULL;
         end else begin
            if (pend_count == 0) sweep_in = (head > trk);
            pos = 0;
            while (pos < pend_count && trk > pend_track[pos]) pos++;
            for (int i = pend_count; i > pos; i--) begin
               pend_track[i] = pend_track[i-1];
               pend_tag[i]   = pend_tag[i-1];
            end
            pend_track[pos] = trk;
            pend_tag[pos]   = tag;
            pend_count++;
         end
      end else if (pend_count == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         k = find_served(sweep_in);
         if (k < 0) begin
            sweep_in = !sweep_in;
            k = find_served(sweep_in);
         end
         if (k < 0) k = 0;
         res.tag   = pend_tag[k];
         res.track = pend_track[k];
         head_pos  = pend_track[k];
         for (int i = k; i + 1 < pend_count; i++) begin
            pend_track[i] = pend_track[i+1];
            pend_tag[i]   = pend_tag[i+1];
         end
         pend_count--;
      end
      res.inward = sweep_in;
      res.count  = pend_count[CNT_W-1:0];
      return res;
   endfunction

   task automatic report_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         pend_count     = 0;
         sweep_in       = 1'b0;
         head_pos       = '0;
         mismatch_count = 0;
         expected_q.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_q.push_back(apply_word(req_opcode, req_track, req_tag, req_head_track));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: result word with none expected, expected nothing, actual %0d",
                        $time, rsp_status);
            end else begin
               want = expected_q.pop_front();
               report_field("status", want.status, rsp_status);
               report_field("served_tag", want.tag, rsp_served_tag);
               report_field("served_track", want.track, rsp_served_track);
               report_field("sweep_inward", want.inward, rsp_sweep_inward);
               report_field("pending_count", want.count, rsp_pending_count);
            end
         end
      end
      results_owed = expected_q.size();
   end

endmodule

// ===== tb/tb_look_disk_request_scheduler_unit.sv =====
`timescale 1ns / 1ps

module tb_look_disk_request_scheduler_unit
   import lds_pkg::*;
();

   localparam int CAP   = CAPACITY_DEFAULT;
   localparam int TRK_W = TRACK_BITS_DEFAULT;
   localparam int TAG_W = TAG_BITS_DEFAULT;
   localparam int CNT_W = $clog2(CAP + 1);

   // The slowest legal run is far below this: about 400 words, each at most a
   // full scan plus random gaps and stalls, plus one long result hold-off.
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RSP_HOLD_CYCLES = 400;
   // A get scans every pending entry, so the drain wait is sized to cover any word in flight.
   localparam int DRAIN_CYCLES    = 60;
   localparam int WORDS_PER_PHASE = 130;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_opcode;
   logic [TRK_W-1:0]  req_track;
   logic [TAG_W-1:0]  req_tag;
   logic [TRK_W-1:0]  req_head_track;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_status;
   logic [TAG_W-1:0]  rsp_served_tag;
   logic [TRK_W-1:0]  rsp_served_track;
   logic              rsp_sweep_inward;
   logic [CNT_W-1:0]  rsp_pending_count;

   int unsigned mismatch_count;
   int unsigned results_owed;
   int unsigned cycle_count = 0;

   // Knobs for the stimulus. The idle percentages change from phase to phase;
   // the hold request asks the receiver for one long hold-off.
   int          send_idle_pct;
   int          rsp_idle_pct;
   bit          rsp_hold_request;
   int          words_sent;
   int          full_hits;
   int          empty_hits;
   // Rough count of what the block holds; steers fill/drain bursts and counts error hits.
   int          queued_estimate;
   logic [TRK_W-1:0] cluster_base;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   look_disk_request_scheduler_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_track         (req_track),
      .req_tag           (req_tag),
      .req_head_track    (req_head_track),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_served_tag    (rsp_served_tag),
      .rsp_served_track  (rsp_served_track),
      .rsp_sweep_inward  (rsp_sweep_inward),
      .rsp_pending_count (rsp_pending_count)
   );

   // The checker sees both channels, predicts every result word and compares.
   lds_service_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_track         (req_track),
      .req_tag           (req_tag),
      .req_head_track    (req_head_track),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_served_tag    (rsp_served_tag),
      .rsp_served_track  (rsp_served_track),
      .rsp_sweep_inward  (rsp_sweep_inward),
      .rsp_pending_count (rsp_pending_count),
      .mismatch_count    (mismatch_count),
      .results_owed      (results_owed)
   );

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_look_disk_request_scheduler_unit: done, errors");
         $finish;
      end
   end

   // Receiver. Each falling edge it decides whether to stall the next result
   // word. When a hold-off is requested it keeps the stall high for a long
   // stretch, once, so the block finishes one word, parks it in its output
   // register, takes the next word and then has to stall its own input.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // Offers one word and returns at the rising edge where the block takes it.
   // Idle cycles before the word drop valid; with no idle cycle valid simply
   // stays high and the payload moves on to the next word.
   task automatic send_word(opcode_type op, logic [TRK_W-1:0] trk,
                            logic [TAG_W-1:0] tag, logic [TRK_W-1:0] head);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_track      <= trk;
      req_tag        <= tag;
      req_head_track <= head;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (op == OP_ADD) begin
         if (queued_estimate < CAP) queued_estimate++;
         else full_hits++;
      end else begin
         if (queued_estimate > 0) queued_estimate--;
         else empty_hits++;
      end
   endtask

   // Tracks lean on the extremes and on a narrow cluster, so that equal
   // tracks and direction flips at the ends of the disk come up often.
   function automatic logic [TRK_W-1:0] pick_track();
      case ($urandom_range(4))
         0:       return $urandom_range(1) ? '1 : '0;
         1:       return cluster_base + TRK_W'($urandom_range(3));
         default: return TRK_W'($urandom_range((1 << TRK_W) - 1));
      endcase
   endfunction

   function automatic logic [TAG_W-1:0] pick_tag();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return TAG_W'($urandom_range((1 << TAG_W) - 1));
      endcase
   endfunction

   task automatic send_add();
      send_word(OP_ADD, pick_track(), pick_tag(), pick_track());
   endtask

   // A get ignores its payload, so the payload is noise.
   task automatic send_get();
      send_word(OP_GET, pick_track(), pick_tag(), pick_track());
   endtask

   // Drops valid and waits until every result word has come back.
   task automatic wait_results_in();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
   endtask

   // Random traffic: runs of mixed adds and gets around one track cluster,
   // bursts that fill the block to full and push a few adds past it, and
   // bursts that drain it to empty and ask once more.
   task automatic run_phase(int n_words);
      int start;
      int len;
      start = words_sent;
      while (words_sent - start < n_words) begin
         case ($urandom_range(9))
            0, 1: begin
               while (queued_estimate < CAP) send_add();
               repeat ($urandom_range(1, 3)) send_add();
            end
            2, 3: begin
               while (queued_estimate > 0) send_get();
               send_get();
            end
            default: begin
               len = $urandom_range(4, 16);
               cluster_base = TRK_W'($urandom_range((1 << TRK_W) - 1));
               repeat (len) begin
                  if ($urandom_range(99) < 50) send_get();
                  else send_add();
               end
            end
         endcase
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_ADD;
      req_track        = '0;
      req_tag          = '0;
      req_head_track   = '0;
      send_idle_pct    = 21;
      rsp_idle_pct     = 68;
      rsp_hold_request = 1'b0;
      words_sent       = 0;
      full_hits        = 0;
      empty_hits       = 0;
      queued_estimate  = 0;
      cluster_base     = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part. A get on the empty block must report the empty error.
      send_word(OP_GET, '0, '0, '0);
      // The first add sees the head above its track and sets the sweep inward.
      send_word(OP_ADD, '0, '0, '1);
      // Later adds ignore the head track and keep the direction.
      send_word(OP_ADD, '1, '1, '0);
      send_word(OP_ADD, 10'd512, 16'h1234, '0);
      // Same track again: the newer request goes in front of the older one.
      send_word(OP_ADD, 10'd512, 16'h5678, '1);
      // Inward from track zero serves track zero, then nothing lies inward,
      // so the sweep flips outward and serves both 512s, newest first, then 1023.
      repeat (4) send_word(OP_GET, '1, '1, '1);
      send_word(OP_GET, '0, '0, '0);
      // Head equal to the track keeps the sweep outward on an empty block.
      send_word(OP_ADD, 10'd100, 16'h00aa, 10'd100);
      send_word(OP_ADD, 10'd100, 16'h00bb, 10'd1000);
      send_word(OP_ADD, 10'd5, 16'h00cc, 10'd0);
      send_word(OP_ADD, 10'd900, 16'h00dd, 10'd3);
      send_word(OP_ADD, 10'd1023, 16'hffff, 10'd0);
      // Outward from 1023 serves 1023, then turns inward to 900, both 100s
      // and 5; the last get finds the block empty.
      repeat (6) send_word(OP_GET, '0, '0, '0);

      // Phase one: the sender idles a little and the receiver a lot.
      run_phase(WORDS_PER_PHASE);
      wait_results_in();

      // Phase two: the other way round.
      send_idle_pct = 68;
      rsp_idle_pct  = 21;
      run_phase(WORDS_PER_PHASE);
      wait_results_in();

      // Phase three: nobody idles, and it opens with the long result hold-off
      // while words keep coming, so the input side backs up.
      send_idle_pct    = 0;
      rsp_idle_pct     = 0;
      rsp_hold_request = 1'b1;
      run_phase(WORDS_PER_PHASE);

      wait_results_in();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run sent %0d words: directed sweep and tie cases, %0d adds past full, %0d gets on empty,",
               words_sent, full_hits, empty_hits);
      $display("three idle patterns and one %0d-cycle result hold-off.", RSP_HOLD_CYCLES);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("tb_look_disk_request_scheduler_unit: done, clean");
      end else begin
         $display("tb_look_disk_request_scheduler_unit: done, errors");
      end
      $finish;
   end

endmodule
